### rtl/framed_byte_link_receiver_assert.svh
// Assertion macros shared by the framed byte link receiver RTL.
`ifndef FRAMED_BYTE_LINK_RECEIVER_ASSERT_SVH
`define FRAMED_BYTE_LINK_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FBLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("framed byte link receiver check failed");

// Next-cycle implication, checked out of reset.
`define FBLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("framed byte link receiver check failed");

`endif

### rtl/fblr_pkg.sv
// Shared types and constants of the framed byte link receiver.
`default_nettype none

package fblr_pkg;

    localparam int unsigned CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_HEAD     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_FIXED    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TYPE     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TAIL     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MAX_LEN  = 3'd4;

    localparam logic [7:0] HEAD_RST    = 8'h68;
    localparam logic [7:0] FIXED_RST   = 8'h45;
    localparam logic [7:0] TYPE_RST    = 8'h00;
    localparam logic [7:0] TAIL_RST    = 8'h16;
    localparam logic [7:0] MAX_LEN_RST = 8'd128;

    localparam logic [7:0] CON_BCD     = 8'h11;

    typedef enum logic [1:0] {
        EV_ACCEPT  = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_DONE    = 2'd2,
        EV_REJECT  = 2'd3
    } t_event;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] fixed_byte;
        logic [7:0] type_byte;
        logic [7:0] tail_byte;
        logic [7:0] max_payload_len;
    } t_cfg;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  cmd_first;
        logic [7:0]  cmd_second;
        logic [15:0] guid;
        logic [7:0]  control_first;
        logic [7:0]  control_second;
        logic [7:0]  payload_length;
        logic [7:0]  checksum_byte;
        logic        checksum_ok;
        logic [14:0] decoded_value;
    } t_result;

endpackage

`default_nettype wire

### rtl/fblr_parser.sv
// Frame parser: phase register, held header fields and per-byte result.
`default_nettype none

module fblr_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    input  wire fblr_pkg::t_cfg   i_cfg,
    output fblr_pkg::t_result     o_result
);
    import fblr_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_HEAD  = 4'd1,
        PH_FIXED = 4'd2,
        PH_TYPE  = 4'd3,
        PH_CMD0  = 4'd4,
        PH_GUIDB = 4'd5,
        PH_GUID  = 4'd6,
        PH_CON0  = 4'd7,
        PH_CON1  = 4'd8,
        PH_DATA  = 4'd9,
        PH_CS    = 4'd10,
        PH_TAIL  = 4'd11
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic        r_half,     n_half;
    logic [7:0]  r_cmd0,     n_cmd0;
    logic [7:0]  r_cmd1,     n_cmd1;
    logic [15:0] r_guid,     n_guid;
    logic [7:0]  r_con0,     n_con0;
    logic [7:0]  r_con1,     n_con1;
    logic [7:0]  r_length,   n_length;
    logic [7:0]  r_count,    n_count;
    logic [15:0] r_first,    n_first;
    logic [7:0]  r_sum,      n_sum;
    logic [7:0]  r_checksum, n_checksum;

    logic        w_reject;
    logic        w_done;
    logic        w_add_sum;
    logic [7:0]  w_count_inc;
    logic [14:0] w_bcd;
    t_result     w_res;

    assign w_count_inc = r_count + 8'd1;

    assign w_bcd = (r_con0 == CON_BCD)
                 ? (15'(r_first[15:12]) * 15'd1000 + 15'(r_first[11:8]) * 15'd100
                    + 15'(r_first[7:4]) * 15'd10 + 15'(r_first[3:0]))
                 : 15'd0;

    always_comb begin
        n_phase    = r_phase;
        n_half     = r_half;
        n_cmd0     = r_cmd0;
        n_cmd1     = r_cmd1;
        n_guid     = r_guid;
        n_con0     = r_con0;
        n_con1     = r_con1;
        n_length   = r_length;
        n_count    = r_count;
        n_first    = r_first;
        n_sum      = r_sum;
        n_checksum = r_checksum;
        w_reject   = 1'b0;
        w_done     = 1'b0;
        w_add_sum  = 1'b1;
        w_res      = '0;
        w_res.event_res = EV_ACCEPT;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == i_cfg.head_byte) n_phase = PH_HEAD;
                else w_reject = 1'b1;
            end
            PH_HEAD: begin
                if (i_byte == i_cfg.fixed_byte) n_phase = PH_FIXED;
                else w_reject = 1'b1;
            end
            PH_FIXED: begin
                if (i_byte == i_cfg.type_byte) n_phase = PH_TYPE;
                else w_reject = 1'b1;
            end
            PH_TYPE: begin
                n_cmd0  = i_byte;
                n_phase = PH_CMD0;
            end
            PH_CMD0: begin
                n_cmd1  = i_byte;
                n_half  = 1'b0;
                n_phase = PH_GUIDB;
            end
            PH_GUIDB: begin
                if (!r_half) begin
                    n_guid = {8'd0, i_byte};
                    n_half = 1'b1;
                end else begin
                    n_guid  = {r_guid[7:0], i_byte};
                    n_phase = PH_GUID;
                end
            end
            PH_GUID: begin
                n_con0  = i_byte;
                n_phase = PH_CON0;
            end
            PH_CON0: begin
                n_con1  = i_byte;
                n_phase = PH_CON1;
            end
            PH_CON1: begin
                if (i_byte <= i_cfg.max_payload_len) begin
                    n_length = i_byte;
                    n_count  = 8'd0;
                    n_phase  = PH_DATA;
                end else begin
                    w_reject = 1'b1;
                end
            end
            PH_DATA: begin
                if (r_count == 8'd0) n_first = {i_byte, 8'd0};
                else if (r_count == 8'd1) n_first = {r_first[15:8], i_byte};
                w_res.event_res     = EV_PAYLOAD;
                w_res.payload_byte  = i_byte;
                w_res.payload_index = r_count;
                n_count = w_count_inc;
                if (w_count_inc >= r_length) n_phase = PH_CS;
            end
            PH_CS: begin
                n_checksum = i_byte;
                n_phase    = PH_TAIL;
                w_add_sum  = 1'b0;
            end
            PH_TAIL: begin
                if (i_byte == i_cfg.tail_byte) begin
                    w_done = 1'b1;
                    w_res.event_res      = EV_DONE;
                    w_res.cmd_first      = r_cmd0;
                    w_res.cmd_second     = r_cmd1;
                    w_res.guid           = r_guid;
                    w_res.control_first  = r_con0;
                    w_res.control_second = r_con1;
                    w_res.payload_length = r_length;
                    w_res.checksum_byte  = r_checksum;
                    w_res.checksum_ok    = (r_sum == r_checksum);
                    w_res.decoded_value  = w_bcd;
                end else begin
                    w_reject = 1'b1;
                end
            end
            default: w_reject = 1'b1;
        endcase

        if (w_reject) w_res.event_res = EV_REJECT;

        if (w_reject || w_done) begin
            n_phase    = PH_IDLE;
            n_half     = 1'b0;
            n_cmd0     = 8'd0;
            n_cmd1     = 8'd0;
            n_guid     = 16'd0;
            n_con0     = 8'd0;
            n_con1     = 8'd0;
            n_length   = 8'd0;
            n_count    = 8'd0;
            n_first    = 16'd0;
            n_sum      = 8'd0;
            n_checksum = 8'd0;
        end else if (w_add_sum) begin
            n_sum = r_sum + i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_half     <= 1'b0;
            r_cmd0     <= 8'd0;
            r_cmd1     <= 8'd0;
            r_guid     <= 16'd0;
            r_con0     <= 8'd0;
            r_con1     <= 8'd0;
            r_length   <= 8'd0;
            r_count    <= 8'd0;
            r_first    <= 16'd0;
            r_sum      <= 8'd0;
            r_checksum <= 8'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_half     <= n_half;
            r_cmd0     <= n_cmd0;
            r_cmd1     <= n_cmd1;
            r_guid     <= n_guid;
            r_con0     <= n_con0;
            r_con1     <= n_con1;
            r_length   <= n_length;
            r_count    <= n_count;
            r_first    <= n_first;
            r_sum      <= n_sum;
            r_checksum <= n_checksum;
        end
    end

    assign o_result = w_res;

endmodule

`default_nettype wire

### rtl/framed_byte_link_receiver.sv
// Top level of the framed byte link receiver: input register, parser and result register.
// An accepted byte is held in the input register until it advances; its result is then captured in the result register.
// Throughput: one byte per cycle; the input register advances into the parser whenever
// the result register is empty or its transfer completes in the same cycle.
// Reset is synchronous and active low; it clears both registers' valid flags, the
// parser state, and restores the match registers to their default values.
`default_nettype none

module framed_byte_link_receiver (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [fblr_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [7:0]                   i_cfg_wdata,
    input  wire logic                         i_rx_valid,
    output logic                              o_rx_ready,
    input  wire logic [7:0]                   i_rx_byte,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output logic [1:0]                        o_event_res,
    output logic [7:0]                        o_payload_byte,
    output logic [7:0]                        o_payload_index,
    output logic [7:0]                        o_cmd_first,
    output logic [7:0]                        o_cmd_second,
    output logic [15:0]                       o_guid,
    output logic [7:0]                        o_control_first,
    output logic [7:0]                        o_control_second,
    output logic [7:0]                        o_payload_length,
    output logic [7:0]                        o_checksum_byte,
    output logic                              o_checksum_ok,
    output logic [14:0]                       o_decoded_value
);
    import fblr_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_advance;

    assign w_advance  = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte       <= HEAD_RST;
            r_cfg.fixed_byte      <= FIXED_RST;
            r_cfg.type_byte       <= TYPE_RST;
            r_cfg.tail_byte       <= TAIL_RST;
            r_cfg.max_payload_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEAD:    r_cfg.head_byte       <= i_cfg_wdata;
                CFG_FIXED:   r_cfg.fixed_byte      <= i_cfg_wdata;
                CFG_TYPE:    r_cfg.type_byte       <= i_cfg_wdata;
                CFG_TAIL:    r_cfg.tail_byte       <= i_cfg_wdata;
                CFG_MAX_LEN: r_cfg.max_payload_len <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx_valid && o_rx_ready) r_in_valid <= 1'b1;
            else if (w_advance) r_in_valid <= 1'b0;

            if (w_advance) r_out_valid <= 1'b1;
            else if (i_res_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) r_in_byte <= i_rx_byte;
        if (w_advance) r_out <= w_result;
    end

    fblr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    assign o_res_valid      = r_out_valid;
    assign o_event_res      = r_out.event_res;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_index  = r_out.payload_index;
    assign o_cmd_first      = r_out.cmd_first;
    assign o_cmd_second     = r_out.cmd_second;
    assign o_guid           = r_out.guid;
    assign o_control_first  = r_out.control_first;
    assign o_control_second = r_out.control_second;
    assign o_payload_length = r_out.payload_length;
    assign o_checksum_byte  = r_out.checksum_byte;
    assign o_checksum_ok    = r_out.checksum_ok;
    assign o_decoded_value  = r_out.decoded_value;

`include "framed_byte_link_receiver_assert.svh"

    `FBLR_ASSERT_NEXT(a_in_hold, r_in_valid && !w_advance, r_in_valid && $stable(r_in_byte))
    `FBLR_ASSERT_NOW(a_index_range, r_out_valid && r_out.event_res == EV_PAYLOAD,
        r_out.payload_index != 8'hFF)
    `FBLR_ASSERT_NOW(a_payload_zero, r_out_valid && r_out.event_res != EV_PAYLOAD,
        r_out.payload_byte == 8'd0 && r_out.payload_index == 8'd0)
    `FBLR_ASSERT_NOW(a_bcd_only_done, r_out_valid && r_out.decoded_value != 15'd0,
        r_out.event_res == EV_DONE && r_out.control_first == CON_BCD)

endmodule

`default_nettype wire
